// ===== src/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// tds_pkg
// Shared types and constants of the task device selector.
// ----------------------------------------------------------------------------
package tds_pkg;

  // Verdict codes, in the order in which the checks are made.
  localparam logic [3:0] VERDICT_OK      = 4'd0;
  localparam logic [3:0] VERDICT_OFFLINE = 4'd1;
  localparam logic [3:0] VERDICT_RAM     = 4'd2;
  localparam logic [3:0] VERDICT_ADC     = 4'd3;
  localparam logic [3:0] VERDICT_QFULL   = 4'd9;

  localparam int CAP_BITS = 6;

  // Configuration register indexes.
  localparam logic [1:0] REG_CPU_WEIGHT     = 2'd0;
  localparam logic [1:0] REG_QUEUE_WEIGHT   = 2'd1;
  localparam logic [1:0] REG_LATENCY_WEIGHT = 2'd2;

  localparam logic [15:0] WEIGHT_RESET = 16'd256;

  // floor(x * 65536 / 100) == (x * RECIP_100) >> RECIP_SHIFT for any 16-bit x.
  localparam logic [31:0] RECIP_100   = 32'd2748779070;
  localparam int          RECIP_SHIFT = 22;

  localparam int SCORE_W = 34;
  localparam int PROD_W  = 48;
  localparam int TERM_W  = 26;

  typedef struct packed {
    logic [15:0] cpu_gain;
    logic [15:0] queue_gain;
    logic [15:0] lat_gain;
  } weights_t;

  // One classified device record as it travels from front to back.
  typedef struct packed {
    logic [7:0]  device_id;
    logic [3:0]  verdict;
    logic [6:0]  cpu_load;
    logic [15:0] delay_ms;
    logic [7:0]  queue_len;
    logic [7:0]  queue_cap;
    logic        last_device;
  } item_t;

endpackage

// ===== src/tds_front.sv =====
// ----------------------------------------------------------------------------
// tds_front
// Eligibility check of one device record; packs the record for the back end.
// ----------------------------------------------------------------------------
module tds_front (
  input  logic [7:0]      device_id,
  input  logic            online,
  input  logic [15:0]     ram_avail,
  input  logic [5:0]      capability_mask,
  input  logic [7:0]      queue_len,
  input  logic [7:0]      queue_cap,
  input  logic [6:0]      cpu_load,
  input  logic [15:0]     delay_ms,
  input  logic [15:0]     ram_needed,
  input  logic [5:0]      need_mask,
  input  logic            last_device,
  output tds_pkg::item_t  item
);

  logic [5:0] missing;
  logic [3:0] verdict;

  assign missing = need_mask & ~capability_mask;

  // The lowest missing capability decides the verdict among the capability checks.
  always_comb begin
    verdict = tds_pkg::VERDICT_OK;
    priority if (!online) begin
      verdict = tds_pkg::VERDICT_OFFLINE;
    end else if (ram_avail < ram_needed) begin
      verdict = tds_pkg::VERDICT_RAM;
    end else if (missing != 6'd0) begin
      for (int b = tds_pkg::CAP_BITS - 1; b >= 0; b--) begin
        if (missing[b]) begin
          verdict = tds_pkg::VERDICT_ADC + 4'(b);
        end
      end
    end else if (queue_len >= queue_cap) begin
      verdict = tds_pkg::VERDICT_QFULL;
    end else begin
      verdict = tds_pkg::VERDICT_OK;
    end
  end

  always_comb begin
    item.device_id   = device_id;
    item.verdict     = verdict;
    item.cpu_load    = cpu_load;
    item.delay_ms    = delay_ms;
    item.queue_len   = queue_len;
    item.queue_cap   = queue_cap;
    item.last_device = last_device;
  end

endmodule

// ===== src/tds_queue.sv =====
// ----------------------------------------------------------------------------
// tds_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module tds_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  tds_pkg::item_t  wr_data,
  output logic            full,
  input  logic            rd_en,
  output tds_pkg::item_t  rd_data,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  tds_pkg::item_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== src/tds_back.sv =====
// ----------------------------------------------------------------------------
// tds_back
// Scores eligible items, keeps the best device of the task, drives results.
// ----------------------------------------------------------------------------
module tds_back (
  input  logic                  clk,
  input  logic                  rst,
  input  tds_pkg::weights_t     weights,
  input  logic                  q_valid,
  input  tds_pkg::item_t        q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_pop,
  output logic [3:0]            out_verdict,
  output logic [tds_pkg::SCORE_W-1:0] out_score,
  output logic                  out_done,
  output logic                  out_blocked,
  output logic [7:0]            out_chosen
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CPU  = 4'd1;
  localparam logic [3:0] ST_CPUW = 4'd2;
  localparam logic [3:0] ST_LAT  = 4'd3;
  localparam logic [3:0] ST_LATW = 4'd4;
  localparam logic [3:0] ST_ACC  = 4'd5;
  localparam logic [3:0] ST_WAIT = 4'd6;
  localparam logic [3:0] ST_QW   = 4'd7;
  localparam logic [3:0] ST_SUM  = 4'd8;

  localparam int          DIV_STEPS = 16;
  localparam logic [4:0]  DIV_DONE  = 5'(DIV_STEPS);

  localparam int SW = tds_pkg::SCORE_W;
  localparam int PW = tds_pkg::PROD_W;
  localparam int TW = tds_pkg::TERM_W;
  localparam int RS = tds_pkg::RECIP_SHIFT;

  logic [3:0]     state;
  tds_pkg::item_t cur;
  logic [PW-1:0]  prod;
  logic [SW-1:0]  acc;
  logic [7:0]     div_rem;
  logic [15:0]    div_quot;
  logic [4:0]     div_cnt;

  logic [SW-1:0]  top_score;
  logic [7:0]     best_id;
  logic           best_found;

  logic [31:0]    mul_a;
  logic [15:0]    mul_b;
  logic [PW-1:0]  mul_p;
  logic [TW-1:0]  term;
  logic [SW-1:0]  weighted;
  logic [SW-1:0]  sum_score;
  logic           better;
  logic [8:0]     rem_sh;
  logic           rem_ge;
  logic [8:0]     rem_sub;
  logic           take;

  assign take  = (state == ST_IDLE) && !out_valid && q_valid;
  assign q_pop = take;

  assign term     = prod[RS +: TW];
  assign weighted = prod[8 +: SW];

  // One shared multiplier; the operands follow the step of the sequence.
  always_comb begin
    mul_a = tds_pkg::RECIP_100;
    mul_b = 16'd0;
    unique case (state)
      ST_CPU: begin
        mul_b = {9'd0, cur.cpu_load};
      end
      ST_CPUW: begin
        mul_a = {6'd0, term};
        mul_b = weights.cpu_gain;
      end
      ST_LAT: begin
        mul_b = cur.delay_ms;
      end
      ST_LATW: begin
        mul_a = {6'd0, term};
        mul_b = weights.lat_gain;
      end
      ST_QW: begin
        mul_a = {16'd0, div_quot};
        mul_b = weights.queue_gain;
      end
      default: begin
        mul_a = tds_pkg::RECIP_100;
        mul_b = 16'd0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Restoring division of the queue length * 65536 by the capacity, one bit a cycle.
  // The remainder starts at the queue length, which is below the capacity.
  assign rem_sh  = {div_rem, 1'b0};
  assign rem_ge  = (rem_sh >= {1'b0, cur.queue_cap});
  assign rem_sub = rem_sh - {1'b0, cur.queue_cap};

  assign sum_score = acc + weighted;
  assign better    = (sum_score < top_score);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      top_score  <= '1;
      best_id    <= 8'd0;
      best_found <= 1'b0;
      div_cnt    <= DIV_DONE;
    end else begin
      if (out_valid && out_pop) begin
        out_valid <= 1'b0;
      end

      if (div_cnt != DIV_DONE) begin
        div_rem  <= rem_ge ? rem_sub[7:0] : rem_sh[7:0];
        div_quot <= {div_quot[14:0], rem_ge};
        div_cnt  <= div_cnt + 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (take) begin
            cur <= q_item;
            if (q_item.verdict == tds_pkg::VERDICT_OK) begin
              div_rem  <= q_item.queue_len;
              div_quot <= 16'd0;
              div_cnt  <= 5'd0;
              state    <= ST_CPU;
            end else begin
              out_valid   <= 1'b1;
              out_verdict <= q_item.verdict;
              out_score   <= '0;
              out_done    <= q_item.last_device;
              out_blocked <= q_item.last_device && !best_found;
              out_chosen  <= (q_item.last_device && best_found) ? best_id : 8'd0;
              if (q_item.last_device) begin
                top_score  <= '1;
                best_id    <= 8'd0;
                best_found <= 1'b0;
              end
            end
          end
        end
        ST_CPU: begin
          prod  <= mul_p;
          state <= ST_CPUW;
        end
        ST_CPUW: begin
          prod  <= mul_p;
          state <= ST_LAT;
        end
        ST_LAT: begin
          acc   <= weighted;
          prod  <= mul_p;
          state <= ST_LATW;
        end
        ST_LATW: begin
          prod  <= mul_p;
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc   <= sum_score;
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_cnt == DIV_DONE) begin
            state <= ST_QW;
          end
        end
        ST_QW: begin
          prod  <= mul_p;
          state <= ST_SUM;
        end
        ST_SUM: begin
          out_valid   <= 1'b1;
          out_verdict <= tds_pkg::VERDICT_OK;
          out_score   <= sum_score;
          out_done    <= cur.last_device;
          out_blocked <= 1'b0;
          if (cur.last_device) begin
            out_chosen <= better ? cur.device_id : best_id;
          end else begin
            out_chosen <= 8'd0;
          end
          if (cur.last_device) begin
            top_score  <= '1;
            best_id    <= 8'd0;
            best_found <= 1'b0;
          end else if (better) begin
            top_score  <= sum_score;
            best_id    <= cur.device_id;
            best_found <= 1'b1;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/task_device_selector.sv =====
// ----------------------------------------------------------------------------
// task_device_selector
// Picks the lowest-score eligible device of a task from a stream of records.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Direction  Payload
//  input     push / full           in         device record and task need
//  result    empty / pop           out        verdict, score, task outcome
//  config    cfg_valid / cfg_ready in         cfg_index, cfg_data (weights)
//
// An ineligible item is answered in the cycle after the back end takes it; an
// eligible one waits for the 16-step queue-fill divider, which runs beside the
// shared multiplier that forms the cpu, latency and weighted terms. The back end
// takes the next item only once the result is popped, so it does not start on a
// new record while the result of the last one is still waiting.
// The input queue holds QUEUE_DEPTH items, so records keep arriving while the
// back end is busy or while a result waits to be popped.
// Reset is synchronous; it empties the queues, clears the task state and sets
// all weights to 1.0. Writes to an index beyond the weight list are dropped.
//
module task_device_selector #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  device_id,
  input  logic        online,
  input  logic [15:0] ram_avail,
  input  logic [5:0]  capability_mask,
  input  logic [7:0]  queue_len,
  input  logic [7:0]  queue_cap,
  input  logic [6:0]  cpu_load,
  input  logic [15:0] delay_ms,
  input  logic [15:0] ram_needed,
  input  logic [5:0]  need_mask,
  input  logic        last_device,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  verdict,
  output logic [33:0] score,
  output logic        done_res,
  output logic        blocked,
  output logic [7:0]  chosen_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tds_pkg::weights_t weights;
  tds_pkg::item_t    front_item;
  tds_pkg::item_t    q_item;
  logic              q_empty;
  logic              q_pop;
  logic              out_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      weights.cpu_gain   <= tds_pkg::WEIGHT_RESET;
      weights.queue_gain <= tds_pkg::WEIGHT_RESET;
      weights.lat_gain   <= tds_pkg::WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tds_pkg::REG_CPU_WEIGHT:     weights.cpu_gain   <= cfg_data;
        tds_pkg::REG_QUEUE_WEIGHT:   weights.queue_gain <= cfg_data;
        tds_pkg::REG_LATENCY_WEIGHT: weights.lat_gain   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tds_front u_front (
    .device_id       (device_id),
    .online          (online),
    .ram_avail       (ram_avail),
    .capability_mask (capability_mask),
    .queue_len       (queue_len),
    .queue_cap       (queue_cap),
    .cpu_load        (cpu_load),
    .delay_ms        (delay_ms),
    .ram_needed      (ram_needed),
    .need_mask       (need_mask),
    .last_device     (last_device),
    .item            (front_item)
  );

  tds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  tds_back u_back (
    .clk         (clk),
    .rst         (rst),
    .weights     (weights),
    .q_valid     (!q_empty),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_pop     (pop),
    .out_verdict (verdict),
    .out_score   (score),
    .out_done    (done_res),
    .out_blocked (blocked),
    .out_chosen  (chosen_id)
  );

  assign empty = !out_valid;

endmodule

// ===== src/tds_checker.sv =====
// ----------------------------------------------------------------------------
// tds_checker
// Port-level checks of the task device selector, bound to the top level.
// ----------------------------------------------------------------------------
module tds_checker (
  input logic        clk,
  input logic        rst,
  input logic        pop,
  input logic        empty,
  input logic [3:0]  verdict,
  input logic [33:0] score,
  input logic        done_res,
  input logic        blocked,
  input logic [7:0]  chosen_id
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // A result that is not popped stays on the ports.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(score) && $stable(verdict)))
    else $error("waiting result changed");

  // Only eligible devices carry a score.
  a_score_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && verdict != tds_pkg::VERDICT_OK) |-> (score == 34'd0))
    else $error("ineligible device with a score");

  // Task outcome fields are quiet except on the last record.
  a_outcome_quiet: assert property (@(posedge clk) disable iff (rst)
    (!empty && !done_res) |-> (!blocked && chosen_id == 8'd0))
    else $error("task outcome outside the last record");

  // A blocked task cannot have an eligible final record.
  a_blocked: assert property (@(posedge clk) disable iff (rst)
    (!empty && blocked) |-> (verdict != tds_pkg::VERDICT_OK && chosen_id == 8'd0))
    else $error("blocked task with an eligible device");

endmodule

bind task_device_selector tds_checker u_tds_checker (
  .clk       (clk),
  .rst       (rst),
  .pop       (pop),
  .empty     (empty),
  .verdict   (verdict),
  .score     (score),
  .done_res  (done_res),
  .blocked   (blocked),
  .chosen_id (chosen_id)
);
